// File: sv/abpl_pkg.sv
package abpl_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  localparam logic [1:0] CTR_WEAK_TAKEN     = 2'd2;
  localparam logic [1:0] CTR_WEAK_NOT_TAKEN = 2'd1;
  localparam logic [1:0] CTR_MAX            = 2'd3;
  localparam logic [1:0] CTR_MIN            = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FILL
  } abpl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic predict;
    logic update;
    logic scan_step;
    logic fill;
  } abpl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_update;
    logic need_scan;
    logic scan_last;
  } abpl_status_t;

  function automatic logic [31:0] imm_b(input logic [31:0] w);
    return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] imm_j(input logic [31:0] w);
    return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

endpackage

// File: sv/abpl_ctrl.sv
module abpl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  abpl_pkg::abpl_status_t status_i,
  output abpl_pkg::abpl_cmd_t    cmd_o
);
  import abpl_pkg::*;

  abpl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.is_update) begin
          state_d = status_i.need_scan ? ST_SCAN : ST_IDLE;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_FILL;
      end
      ST_FILL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.predict = !status_i.is_update && out_free;
        cmd_o.update  = status_i.is_update;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.predict) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/abpl_dp.sv
module abpl_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   cmd_i,
  input  logic [31:0]            pc_i,
  input  logic [31:0]            instruction_i,
  input  logic                   resolved_taken_i,
  input  logic [31:0]            resolved_target_i,
  output logic                   br_taken_o,
  output logic [31:0]            next_fetch_pc_o,
  input  abpl_pkg::abpl_cmd_t    ctl_i,
  output abpl_pkg::abpl_status_t status_o
);
  import abpl_pkg::*;

  // request registers
  logic        is_update_q;
  logic [31:0] pc_q;
  logic [31:0] instr_q;
  logic        res_taken_q;
  logic [31:0] res_target_q;

  logic        enable_q;
  logic [31:0] stamp_q;

  // table
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [31:0]              tag_q    [TABLE_ENTRIES];
  logic [1:0]               ctr_q    [TABLE_ENTRIES];
  logic [31:0]              target_q [TABLE_ENTRIES];
  logic [31:0]              estamp_q [TABLE_ENTRIES];

  // victim search
  logic [IDX_W-1:0] scan_idx_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [31:0]      best_stamp_q;

  logic        br_taken_q;
  logic [31:0] next_pc_q;

  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     has_free;
  logic [IDX_W-1:0]         free_idx;

  logic [6:0]  opc;
  logic        is_jal;
  logic        is_jr_br;
  logic [31:0] stamp_inc;
  logic        tbl_taken;
  logic        back_taken;
  logic [31:0] offset;
  logic [31:0] seq_target;
  logic        taken_d;
  logic [31:0] next_pc_d;

  logic             we_stamp;
  logic             we_ctr_tgt;
  logic             we_alloc;
  logic [IDX_W-1:0] wr_idx;
  logic [1:0]       wr_ctr;
  logic [31:0]      wr_stamp;
  logic [1:0]       ctr_sat;
  logic [1:0]       ctr_init;

  // fully associative lookup, lowest index wins
  always_comb begin
    hit_vec  = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (tag_q[i] == pc_q);
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IDX_W'(i);
      if (!valid_q[i]) free_idx = IDX_W'(i);
    end
  end

  assign hit      = |hit_vec;
  assign has_free = !(&valid_q);

  assign opc       = instr_q[6:0];
  assign is_jal    = (opc == OPC_JAL);
  assign is_jr_br  = (opc == OPC_JALR) || (opc == OPC_BRANCH);
  assign stamp_inc = stamp_q + 32'd1;

  assign tbl_taken  = enable_q && is_jr_br && hit && (ctr_q[hit_idx] >= CTR_WEAK_TAKEN);
  assign back_taken = enable_q && (opc == OPC_BRANCH) && !hit && instr_q[31];

  // one adder serves fall-through, JAL and backward-branch targets
  always_comb begin
    if (enable_q && is_jal) begin
      offset = imm_j(instr_q);
    end else if (back_taken) begin
      offset = imm_b(instr_q);
    end else begin
      offset = 32'd4;
    end
  end

  assign seq_target = pc_q + offset;
  assign taken_d    = tbl_taken || back_taken || (enable_q && is_jal);
  assign next_pc_d  = tbl_taken ? target_q[hit_idx] : seq_target;

  always_comb begin
    if (res_taken_q) begin
      ctr_sat  = (ctr_q[hit_idx] == CTR_MAX) ? CTR_MAX : ctr_q[hit_idx] + 2'd1;
      ctr_init = CTR_WEAK_TAKEN;
    end else begin
      ctr_sat  = (ctr_q[hit_idx] == CTR_MIN) ? CTR_MIN : ctr_q[hit_idx] - 2'd1;
      ctr_init = CTR_WEAK_NOT_TAKEN;
    end
  end

  always_comb begin
    we_stamp   = 1'b0;
    we_ctr_tgt = 1'b0;
    we_alloc   = 1'b0;
    wr_idx     = hit_idx;
    wr_ctr     = ctr_sat;
    wr_stamp   = stamp_inc;
    if (ctl_i.predict && enable_q && is_jr_br && hit) begin
      we_stamp = 1'b1;
    end else if (ctl_i.update && enable_q) begin
      if (hit) begin
        we_stamp   = 1'b1;
        we_ctr_tgt = 1'b1;
      end else if (has_free) begin
        we_stamp   = 1'b1;
        we_ctr_tgt = 1'b1;
        we_alloc   = 1'b1;
        wr_idx     = free_idx;
        wr_ctr     = ctr_init;
      end
    end else if (ctl_i.fill) begin
      // stamp already advanced when the update was taken
      we_stamp   = 1'b1;
      we_ctr_tgt = 1'b1;
      we_alloc   = 1'b1;
      wr_idx     = best_idx_q;
      wr_ctr     = ctr_init;
      wr_stamp   = stamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      stamp_q  <= '0;
      valid_q  <= '0;
    end else begin
      if (cfg_we_i) enable_q <= cfg_wdata_i;
      if ((ctl_i.predict && enable_q && is_jr_br) || (ctl_i.update && enable_q)) begin
        stamp_q <= stamp_inc;
      end
      if (we_alloc) valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_stamp) estamp_q[wr_idx] <= wr_stamp;
    if (we_ctr_tgt) begin
      ctr_q[wr_idx]    <= wr_ctr;
      target_q[wr_idx] <= res_target_q;
    end
    if (we_alloc) tag_q[wr_idx] <= pc_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      is_update_q  <= (cmd_i == CMD_UPDATE);
      pc_q         <= pc_i;
      instr_q      <= instruction_i;
      res_taken_q  <= resolved_taken_i;
      res_target_q <= resolved_target_i;
      scan_idx_q   <= IDX_W'(1);
      best_idx_q   <= '0;
      best_stamp_q <= estamp_q[0];
    end else if (ctl_i.scan_step) begin
      scan_idx_q <= scan_idx_q + IDX_W'(1);
      // strict compare keeps the lowest index on ties
      if (estamp_q[scan_idx_q] < best_stamp_q) begin
        best_idx_q   <= scan_idx_q;
        best_stamp_q <= estamp_q[scan_idx_q];
      end
    end
    if (ctl_i.predict) begin
      br_taken_q <= taken_d;
      next_pc_q  <= next_pc_d;
    end
  end

  assign status_o.is_update = is_update_q;
  assign status_o.need_scan = enable_q && !hit && !has_free;
  assign status_o.scan_last = (scan_idx_q == IDX_W'(TABLE_ENTRIES - 1));

  assign br_taken_o      = br_taken_q;
  assign next_fetch_pc_o = next_pc_q;

endmodule

// File: sv/assoc_branch_predictor_lru_top.sv
// Channel   Handshake                 Payload
// config    cfg_we_i                  cfg_wdata_i (predict_enable)
// request   in_valid_i / in_stall_o   cmd_i, pc_i, instruction_i, resolved_taken_i,
//                                     resolved_target_i
// result    out_valid_o / out_stall_i br_taken_o, next_fetch_pc_o
//
// A request is accepted, then executed: parallel tag compare and table write.
// An update that misses on a full table adds a victim search over the stamps, one entry
// per cycle from entry 1, plus a fill state that writes the chosen victim entry.
// A predict waits in the execute state while the result register is held by out_stall_i.
// Reset empties the table, clears the stamp and enables prediction.
module assoc_branch_predictor_lru_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] instruction_i,
  input  logic        resolved_taken_i,
  input  logic [31:0] resolved_target_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        br_taken_o,
  output logic [31:0] next_fetch_pc_o
);
  import abpl_pkg::*;

  abpl_cmd_t    ctl;
  abpl_status_t status;

  abpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (ctl)
  );

  abpl_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd_i),
    .pc_i              (pc_i),
    .instruction_i     (instruction_i),
    .resolved_taken_i  (resolved_taken_i),
    .resolved_target_i (resolved_target_i),
    .br_taken_o        (br_taken_o),
    .next_fetch_pc_o   (next_fetch_pc_o),
    .ctl_i             (ctl),
    .status_o          (status)
  );

endmodule
